// ===== sv/fbas_pkg.sv =====
// fbas_pkg: widths, stage counts, register indexes and control types
// shared by the FFT bin amplitude scaler modules. No dependencies.
package fbas_pkg;

  localparam int IN_W     = 16;  // bin real / imaginary width
  localparam int SQ_W     = 32;  // re^2 + im^2
  localparam int ROOT_W   = 16;  // floor sqrt result
  localparam int NUM_W    = 17;  // dividend: root or 2*root
  localparam int DIV_W    = 13;  // vector_length
  localparam int OUT_W    = 32;
  localparam int MASK_W   = 12;
  localparam int L2_W     = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  localparam int SQRT_STAGES   = SQ_W / 2;              // one root bit per stage
  localparam int DIV_PER_STAGE = 2;                     // quotient bits per stage
  localparam int DIV_STAGES    = (NUM_W + DIV_PER_STAGE - 1) / DIV_PER_STAGE;

  localparam logic [L2_W-1:0]   LOG2_SIZE_RST  = 4'd6;
  localparam logic [MASK_W-1:0] MASK_RST       = 12'd0;
  localparam logic [DIV_W-1:0]  VECTOR_LEN_RST = 13'd64;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOG2_SIZE  = 2'd0,
    CFG_STAGE_MASK = 2'd1,
    CFG_VECTOR_LEN = 2'd2
  } cfg_idx_t;

  // control that rides alongside the datapath
  typedef struct packed {
    logic valid;
    logic dc;
  } ctl_t;

endpackage

// ===== sv/fbas_sqrt.sv =====
// fbas_sqrt: pipelined floor square root of a 32-bit value, one root bit
// per stage. Depends on fbas_pkg.
module fbas_sqrt (
  input  logic                         clk,
  input  logic                         rst_n,
  input  fbas_pkg::ctl_t               in_ctl,
  input  logic [fbas_pkg::SQ_W-1:0]    in_x,
  output fbas_pkg::ctl_t               out_ctl,
  output logic [fbas_pkg::ROOT_W-1:0]  out_root
);

  localparam int STAGES = fbas_pkg::SQRT_STAGES;
  localparam int W      = fbas_pkg::SQ_W;

  fbas_pkg::ctl_t ctl_r   [STAGES];
  logic [W-1:0]   rem_r   [STAGES];
  logic [W-1:0]   root_r  [STAGES];

  fbas_pkg::ctl_t ctl_src  [STAGES];
  logic [W-1:0]   rem_src  [STAGES];
  logic [W-1:0]   root_src [STAGES];
  logic [W-1:0]   rem_nxt  [STAGES];
  logic [W-1:0]   root_nxt [STAGES];

  always_comb begin
    ctl_src[0]  = in_ctl;
    rem_src[0]  = in_x;
    root_src[0] = '0;
    for (int k = 1; k < STAGES; k++) begin
      ctl_src[k]  = ctl_r[k-1];
      rem_src[k]  = rem_r[k-1];
      root_src[k] = root_r[k-1];
    end
  end

  // non-restoring-free digit step: trial = root + bit, bit = 4^(15-k)
  always_comb begin
    logic [W-1:0] trial;
    logic [W-1:0] bit_k;
    for (int k = 0; k < STAGES; k++) begin
      bit_k = W'(1) << (W - 2 - 2 * k);
      trial = root_src[k] + bit_k;
      if (rem_src[k] >= trial) begin
        rem_nxt[k]  = rem_src[k] - trial;
        root_nxt[k] = (root_src[k] >> 1) + bit_k;
      end else begin
        rem_nxt[k]  = rem_src[k];
        root_nxt[k] = root_src[k] >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < STAGES; k++) begin
      if (!rst_n) begin
        ctl_r[k] <= '0;
      end else begin
        ctl_r[k] <= ctl_src[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < STAGES; k++) begin
      rem_r[k]  <= rem_nxt[k];
      root_r[k] <= root_nxt[k];
    end
  end

  assign out_ctl  = ctl_r[STAGES-1];
  assign out_root = root_r[STAGES-1][fbas_pkg::ROOT_W-1:0];

  logic [33:0] root_sq;
  logic [33:0] root_p1_sq;
  assign root_sq    = 34'(out_root) * 34'(out_root);
  assign root_p1_sq = (34'(out_root) + 34'd1) * (34'(out_root) + 34'd1);

  // root is the floor square root of the value that entered the pipe
  a_root_floor: assert property (@(posedge clk) disable iff (!rst_n)
    out_ctl.valid |-> (root_sq <= 34'($past(in_x, STAGES)))
                   && (root_p1_sq > 34'($past(in_x, STAGES))))
    else $error("sqrt result is not the floor root");

endmodule

// ===== sv/fbas_div.sv =====
// fbas_div: pipelined restoring divider, 17-bit dividend by 13-bit divisor,
// two quotient bits per stage. Depends on fbas_pkg.
module fbas_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic [fbas_pkg::NUM_W-1:0]  in_num,
  input  logic [fbas_pkg::DIV_W-1:0]  in_div,
  output logic                        out_valid,
  output logic [fbas_pkg::NUM_W-1:0]  out_quot
);

  localparam int STAGES = fbas_pkg::DIV_STAGES;
  localparam int PER    = fbas_pkg::DIV_PER_STAGE;
  localparam int NW     = fbas_pkg::NUM_W;
  localparam int DW     = fbas_pkg::DIV_W;

  logic          vld_r  [STAGES];
  logic [DW-1:0] rem_r  [STAGES];
  logic [NW-1:0] num_r  [STAGES];
  logic [NW-1:0] quot_r [STAGES];

  logic          vld_src  [STAGES];
  logic [DW-1:0] rem_src  [STAGES];
  logic [NW-1:0] num_src  [STAGES];
  logic [NW-1:0] quot_src [STAGES];
  logic [DW-1:0] rem_nxt  [STAGES];
  logic [NW-1:0] num_nxt  [STAGES];
  logic [NW-1:0] quot_nxt [STAGES];

  always_comb begin
    vld_src[0]  = in_valid;
    rem_src[0]  = '0;
    num_src[0]  = in_num;
    quot_src[0] = '0;
    for (int s = 1; s < STAGES; s++) begin
      vld_src[s]  = vld_r[s-1];
      rem_src[s]  = rem_r[s-1];
      num_src[s]  = num_r[s-1];
      quot_src[s] = quot_r[s-1];
    end
  end

  // dividend bits leave at the MSB of num, quotient bits enter at the LSB
  always_comb begin
    logic [DW:0]   trial;
    logic [DW-1:0] rem;
    logic [NW-1:0] num;
    logic [NW-1:0] quot;
    for (int s = 0; s < STAGES; s++) begin
      rem  = rem_src[s];
      num  = num_src[s];
      quot = quot_src[s];
      for (int j = 0; j < PER; j++) begin
        if (s * PER + j < NW) begin
          trial = {rem, num[NW-1]};
          num   = num << 1;
          if (trial >= {1'b0, in_div}) begin
            rem  = DW'(trial - {1'b0, in_div});
            quot = {quot[NW-2:0], 1'b1};
          end else begin
            rem  = trial[DW-1:0];
            quot = {quot[NW-2:0], 1'b0};
          end
        end
      end
      rem_nxt[s]  = rem;
      num_nxt[s]  = num;
      quot_nxt[s] = quot;
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < STAGES; s++) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else begin
        vld_r[s] <= vld_src[s];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < STAGES; s++) begin
      rem_r[s]  <= rem_nxt[s];
      num_r[s]  <= num_nxt[s];
      quot_r[s] <= quot_nxt[s];
    end
  end

  assign out_valid = vld_r[STAGES-1];
  assign out_quot  = quot_r[STAGES-1];

  logic [31:0] q_times_d;
  logic [31:0] q1_times_d;
  assign q_times_d  = 32'(out_quot) * 32'(in_div);
  assign q1_times_d = (32'(out_quot) + 32'd1) * 32'(in_div);

  // user keeps divisor static with items in flight, unenforced: exact floor
  a_quot_floor: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (in_div != '0)) |->
      (q_times_d <= 32'($past(in_num, STAGES)))
      && (q1_times_d > 32'($past(in_num, STAGES))))
    else $error("divider quotient is not the floor quotient");

endmodule

// ===== sv/fft_bin_amplitude_scaler_top.sv =====
// fft_bin_amplitude_scaler_top: |bin| = isqrt(re^2+im^2), doubled unless DC,
// divided by vector_length, shifted left by counted stage-mask bits.
// Uses fbas_pkg, fbas_sqrt, fbas_div. An accepted transfer passes stage 1,
// stage 2, sqrt and divider stages and output register. One transfer every
// cycle, busy is low except in reset; sqrt stages take one root bit each.
// Sync reset clears all valid bits and loads the register defaults.
module fft_bin_amplitude_scaler_top #(
  parameter int MAX_SIZE = 4096
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input channel
  input  logic                                start,
  output logic                                busy,
  input  logic signed [fbas_pkg::IN_W-1:0]    in_bin_real,
  input  logic signed [fbas_pkg::IN_W-1:0]    in_bin_imag,
  input  logic                                in_is_dc_bin,
  // result channel, one-cycle strobe, no backpressure
  output logic                                out_strobe,
  output logic [fbas_pkg::OUT_W-1:0]          out_scaled_amplitude,
  // configuration write port
  input  logic                                cfg_we,
  input  logic [fbas_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fbas_pkg::CFG_DATA_W-1:0]     cfg_data
);

  // only mask bits below log2(MAX_SIZE) can ever count
  localparam int LOG2_MAX = $clog2(MAX_SIZE);
  localparam int CNT_MAX  = (LOG2_MAX < fbas_pkg::MASK_W) ? LOG2_MAX : fbas_pkg::MASK_W;
  localparam int CNT_W    = $clog2(CNT_MAX + 1);
  localparam int LATENCY  = 2 + fbas_pkg::SQRT_STAGES + fbas_pkg::DIV_STAGES + 1;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [fbas_pkg::L2_W-1:0]   log2_size_r;
  logic [fbas_pkg::MASK_W-1:0] mask_r;
  logic [fbas_pkg::DIV_W-1:0]  vector_length_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      log2_size_r     <= fbas_pkg::LOG2_SIZE_RST;
      mask_r          <= fbas_pkg::MASK_RST;
      vector_length_r <= fbas_pkg::VECTOR_LEN_RST;
    end else if (cfg_we) begin
      case (fbas_pkg::cfg_idx_t'(cfg_index))
        fbas_pkg::CFG_LOG2_SIZE:  log2_size_r     <= cfg_data[fbas_pkg::L2_W-1:0];
        fbas_pkg::CFG_STAGE_MASK: mask_r          <= cfg_data[fbas_pkg::MASK_W-1:0];
        fbas_pkg::CFG_VECTOR_LEN: vector_length_r <= cfg_data[fbas_pkg::DIV_W-1:0];
        default: ; // unknown index: write dropped
      endcase
    end
  end

  // Shift count from config, registered. The user changes config only while
  // the pipe is empty (unenforced), so the lag is unseen by the last stage.
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;

  always_comb begin
    cnt_nxt = '0;
    for (int i = 0; i < fbas_pkg::MASK_W; i++) begin
      if ((i < LOG2_MAX) && (fbas_pkg::L2_W'(i) < log2_size_r) && mask_r[i]) begin
        cnt_nxt = cnt_nxt + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: magnitudes and squares
  // ---------------------------------------------------------------------
  function automatic logic [fbas_pkg::IN_W-1:0] abs16(input logic [fbas_pkg::IN_W-1:0] v);
    abs16 = v[fbas_pkg::IN_W-1] ? fbas_pkg::IN_W'(~v + 1'b1) : v;
  endfunction

  assign busy = !rst_n;

  logic                        take;
  logic [fbas_pkg::IN_W-1:0]   re_abs;
  logic [fbas_pkg::IN_W-1:0]   im_abs;
  fbas_pkg::ctl_t              s1_ctl_r;
  fbas_pkg::ctl_t              s1_ctl_nxt;
  logic [fbas_pkg::SQ_W-1:0]   re_sq_r;
  logic [fbas_pkg::SQ_W-1:0]   im_sq_r;

  assign take   = start && !busy;
  assign re_abs = abs16($unsigned(in_bin_real));
  assign im_abs = abs16($unsigned(in_bin_imag));

  always_comb begin
    s1_ctl_nxt.valid = take;
    s1_ctl_nxt.dc    = in_is_dc_bin;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_ctl_r <= '0;
    end else begin
      s1_ctl_r <= s1_ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    re_sq_r <= fbas_pkg::SQ_W'(re_abs) * fbas_pkg::SQ_W'(re_abs);
    im_sq_r <= fbas_pkg::SQ_W'(im_abs) * fbas_pkg::SQ_W'(im_abs);
  end

  // ---------------------------------------------------------------------
  // Stage 2: sum of squares (max 2^31, no carry out)
  // ---------------------------------------------------------------------
  fbas_pkg::ctl_t            s2_ctl_r;
  logic [fbas_pkg::SQ_W-1:0] sum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_ctl_r <= '0;
    end else begin
      s2_ctl_r <= s1_ctl_r;
    end
  end

  always_ff @(posedge clk) begin
    sum_r <= re_sq_r + im_sq_r;
  end

  // ---------------------------------------------------------------------
  // Square root pipeline
  // ---------------------------------------------------------------------
  fbas_pkg::ctl_t              sq_ctl;
  logic [fbas_pkg::ROOT_W-1:0] sq_root;

  fbas_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ctl   (s2_ctl_r),
    .in_x     (sum_r),
    .out_ctl  (sq_ctl),
    .out_root (sq_root)
  );

  // non-DC bins are doubled before the divide
  logic [fbas_pkg::NUM_W-1:0] num;
  assign num = sq_ctl.dc ? {1'b0, sq_root} : {sq_root, 1'b0};

  // ---------------------------------------------------------------------
  // Divide by vector_length
  // ---------------------------------------------------------------------
  logic                       div_valid;
  logic [fbas_pkg::NUM_W-1:0] div_quot;

  fbas_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sq_ctl.valid),
    .in_num    (num),
    .in_div    (vector_length_r),
    .out_valid (div_valid),
    .out_quot  (div_quot)
  );

  // ---------------------------------------------------------------------
  // Output stage: zero divisor gives all ones, then stage rescale
  // ---------------------------------------------------------------------
  logic                       out_strobe_r;
  logic [fbas_pkg::OUT_W-1:0] out_amp_r;
  logic [fbas_pkg::OUT_W-1:0] quot32;
  logic [fbas_pkg::OUT_W-1:0] out_amp_nxt;

  assign quot32      = (vector_length_r == '0) ? '1 : fbas_pkg::OUT_W'(div_quot);
  assign out_amp_nxt = quot32 << cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_amp_r <= out_amp_nxt;
  end

  assign out_strobe           = out_strobe_r;
  assign out_scaled_amplitude = out_amp_r;

  // every accepted transfer produces its strobe a fixed latency later
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LATENCY out_strobe)
    else $error("result strobe missing at expected latency");

  // a strobe only comes from an accepted transfer
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    (!start || busy) |-> ##LATENCY !out_strobe)
    else $error("result strobe without an accepted transfer");

  // zero divisor and no rescale must give the saturated quotient
  a_zero_div: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && (vector_length_r == '0) && (cnt_r == '0)) |->
      (out_scaled_amplitude == '1))
    else $error("zero divisor did not give all ones");

endmodule

// ===== dv/tb_top.sv =====
// tb_top: self-checking testbench for fft_bin_amplitude_scaler_top.
// Predicts each bin's amplitude (isqrt, non-DC doubling, divide, shift) and
// checks every out_strobe transfer in order. Depends on fbas_pkg and the RTL.
`timescale 1ns / 1ps

module tb_top;

  // drain wait covers the transfer-to-strobe pipeline plus slack
  localparam int PIPE_LAT  = 27;
  localparam int DRAIN_PAD = PIPE_LAT + 8;
  localparam int SEG_BINS  = 50;   // bins per register setting in the random part
  localparam int SEG_COUNT = 7;    // settings per idle phase
  localparam int MAX_SHOWN = 10;

  // index 3 has no register behind it
  localparam logic [fbas_pkg::CFG_IDX_W-1:0] CFG_IDX_UNMAPPED = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                             start = 1'b0;
  logic                             busy;
  logic signed [fbas_pkg::IN_W-1:0] in_bin_real = '0;
  logic signed [fbas_pkg::IN_W-1:0] in_bin_imag = '0;
  logic                             in_is_dc_bin = 1'b0;
  logic                             out_strobe;
  logic [fbas_pkg::OUT_W-1:0]       out_scaled_amplitude;
  logic                             cfg_we = 1'b0;
  logic [fbas_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
  logic [fbas_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

  // testbench copy of the register file
  logic [fbas_pkg::L2_W-1:0]   shadow_log2_size;
  logic [fbas_pkg::MASK_W-1:0] shadow_stage_mask;
  logic [fbas_pkg::DIV_W-1:0]  shadow_vector_len;

  logic [fbas_pkg::OUT_W-1:0] pending_amplitudes[$];

  int bins_sent;
  int amplitudes_checked;
  int reg_writes;
  int settings_used;
  int fail_count;

  fft_bin_amplitude_scaler_top u_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_bin_real          (in_bin_real),
    .in_bin_imag          (in_bin_imag),
    .in_is_dc_bin         (in_is_dc_bin),
    .out_strobe           (out_strobe),
    .out_scaled_amplitude (out_scaled_amplitude),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Safety net: ends the run with a failure if it never finishes.
  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  //--------------------------------------------------------------------------
  // Amplitude predictor
  //--------------------------------------------------------------------------
  // floor sqrt by setting root bits from the top while root^2 stays <= x
  function automatic logic [fbas_pkg::ROOT_W-1:0] floor_root(
    input logic [fbas_pkg::SQ_W-1:0] x
  );
    logic [fbas_pkg::ROOT_W-1:0] root;
    logic [fbas_pkg::ROOT_W-1:0] trial;
    root = '0;
    for (int b = fbas_pkg::ROOT_W - 1; b >= 0; b--) begin
      trial = root | (fbas_pkg::ROOT_W'(1) << b);
      if (fbas_pkg::SQ_W'(trial) * fbas_pkg::SQ_W'(trial) <= x) root = trial;
    end
    return root;
  endfunction

  function automatic logic [fbas_pkg::OUT_W-1:0] calc_amplitude(
    input logic signed [fbas_pkg::IN_W-1:0] re,
    input logic signed [fbas_pkg::IN_W-1:0] im,
    input logic                             dc
  );
    logic [fbas_pkg::IN_W:0]     abs_re;
    logic [fbas_pkg::IN_W:0]     abs_im;
    logic [fbas_pkg::SQ_W-1:0]   power;
    logic [fbas_pkg::NUM_W-1:0]  dividend;
    logic [fbas_pkg::OUT_W-1:0]  quot;
    int                          stages;
    // -32768 has magnitude 32768, hence the extra bit
    abs_re   = re[fbas_pkg::IN_W-1] ? (17'h10000 - {1'b0, re}) : {1'b0, re};
    abs_im   = im[fbas_pkg::IN_W-1] ? (17'h10000 - {1'b0, im}) : {1'b0, im};
    power    = fbas_pkg::SQ_W'(abs_re) * fbas_pkg::SQ_W'(abs_re)
             + fbas_pkg::SQ_W'(abs_im) * fbas_pkg::SQ_W'(abs_im);
    dividend = fbas_pkg::NUM_W'(floor_root(power));
    if (!dc) dividend = dividend << 1;
    // zero divisor behaves like a restoring divider: all ones
    if (shadow_vector_len == '0) quot = '1;
    else quot = fbas_pkg::OUT_W'(dividend) / fbas_pkg::OUT_W'(shadow_vector_len);
    // mask bits at or above log2_size, or beyond the 12 stages, don't count
    stages = 0;
    for (int i = 0; i < fbas_pkg::MASK_W; i++)
      if (i < shadow_log2_size && shadow_stage_mask[i]) stages++;
    return quot << stages;
  endfunction

  //--------------------------------------------------------------------------
  // Result checker: every strobe must match the oldest prediction
  //--------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (pending_amplitudes.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_SHOWN)
          $display("[%0t] unexpected result %h with nothing pending",
                   $realtime, out_scaled_amplitude);
      end else begin
        if (out_scaled_amplitude !== pending_amplitudes[0]) begin
          fail_count++;
          if (fail_count <= MAX_SHOWN)
            $display("[%0t] scaled_amplitude mismatch: expected %h actual %h",
                     $realtime, pending_amplitudes[0], out_scaled_amplitude);
        end
        void'(pending_amplitudes.pop_front());
        amplitudes_checked++;
      end
    end
  end

  //--------------------------------------------------------------------------
  // Shared drivers
  //--------------------------------------------------------------------------
  // Leaves start high after the accepting edge so back-to-back bins need no
  // extra assignment; gaps and drains lower it.
  task automatic send_bin(input logic signed [fbas_pkg::IN_W-1:0] re,
                          input logic signed [fbas_pkg::IN_W-1:0] im,
                          input logic dc);
    start        <= 1'b1;
    in_bin_real  <= re;
    in_bin_imag  <= im;
    in_is_dc_bin <= dc;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_amplitudes.push_back(calc_amplitude(re, im, dc));
    bins_sent++;
  endtask

  // sender idles each cycle with the given percentage
  task automatic idle_gap(input int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  // wait until every predicted amplitude came out and the pipe is empty
  task automatic drain_pipeline();
    start <= 1'b0;
    while (pending_amplitudes.size() != 0) @(posedge clk);
    repeat (DRAIN_PAD) @(posedge clk);
  endtask

  task automatic write_reg(input logic [fbas_pkg::CFG_IDX_W-1:0] idx,
                           input logic [fbas_pkg::CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      fbas_pkg::CFG_LOG2_SIZE:  shadow_log2_size  = data[fbas_pkg::L2_W-1:0];
      fbas_pkg::CFG_STAGE_MASK: shadow_stage_mask = data[fbas_pkg::MASK_W-1:0];
      fbas_pkg::CFG_VECTOR_LEN: shadow_vector_len = data[fbas_pkg::DIV_W-1:0];
      default: ;  // unmapped index: write is dropped
    endcase
    reg_writes++;
  endtask

  task automatic set_regs(input logic [fbas_pkg::CFG_DATA_W-1:0] log2_size,
                          input logic [fbas_pkg::CFG_DATA_W-1:0] mask,
                          input logic [fbas_pkg::CFG_DATA_W-1:0] vlen);
    write_reg(fbas_pkg::CFG_LOG2_SIZE, log2_size);
    write_reg(fbas_pkg::CFG_STAGE_MASK, mask);
    write_reg(fbas_pkg::CFG_VECTOR_LEN, vlen);
    settings_used++;
  endtask

  //--------------------------------------------------------------------------
  // Tests
  //--------------------------------------------------------------------------
  // reset values: log2_size 6, no stage bits, divide by 64
  task automatic test_reset_defaults();
    send_bin(16'sd0,      16'sd0,      1'b0);
    send_bin(16'sd0,      16'sd0,      1'b1);
    send_bin(16'sd32767,  16'sd0,      1'b0);
    send_bin(-16'sd32768, 16'sd0,      1'b1);
    send_bin(16'sd0,      -16'sd32768, 1'b0);
    send_bin(-16'sd32768, -16'sd32768, 1'b0);
    send_bin(16'sd32767,  16'sd32767,  1'b1);
    send_bin(-16'sd1,     -16'sd1,     1'b0);
    send_bin(16'sd3,      -16'sd4,     1'b0);
    drain_pipeline();
  endtask

  task automatic test_register_extremes();
    // zero divisor with every stage counted: all-ones quotient wraps left
    set_regs(13'd15, 13'h0FFF, 13'd0);
    send_bin(16'sd1, 16'sd0, 1'b1);
    send_bin(-16'sd32768, -16'sd32768, 1'b0);
    drain_pipeline();
    // largest gain: divide by one, twelve stages
    set_regs(13'd12, 13'h1FFF, 13'd1);
    send_bin(-16'sd32768, -16'sd32768, 1'b0);
    send_bin(16'sd32767, -16'sd1, 1'b1);
    drain_pipeline();
    // log2_size 0 counts nothing; divisor beyond MAX_SIZE used as is
    set_regs(13'h1FF0, 13'h0FFF, 13'h1FFF);
    send_bin(-16'sd32768, -16'sd32768, 1'b0);
    send_bin(16'sd32767, 16'sd32767, 1'b1);
    drain_pipeline();
    // small log2_size only counts the low stage bits
    set_regs(13'd5, 13'h003F, 13'd4096);
    send_bin(-16'sd32768, 16'sd32767, 1'b0);
    send_bin(16'sd100, 16'sd0, 1'b1);
    drain_pipeline();
  endtask

  task automatic test_unmapped_index();
    set_regs(13'd9, 13'h0155, 13'd3);
    write_reg(CFG_IDX_UNMAPPED, 13'h1FFF);
    write_reg(CFG_IDX_UNMAPPED, 13'h0000);
    send_bin(16'sd12345, -16'sd23456, 1'b0);
    send_bin(-16'sd7, 16'sd24, 1'b1);
    drain_pipeline();
  endtask

  function automatic logic signed [fbas_pkg::IN_W-1:0] pick_component();
    logic signed [fbas_pkg::IN_W-1:0] corners[6];
    logic signed [fbas_pkg::IN_W-1:0] v;
    corners = '{-16'sd32768, -16'sd32767, -16'sd1, 16'sd0, 16'sd1, 16'sd32767};
    case ($urandom_range(9))
      0:       v = corners[$urandom_range(5)];
      1, 2: begin
        v = fbas_pkg::IN_W'($urandom_range(31));
        if ($urandom_range(1)) v = -v;
      end
      default: v = fbas_pkg::IN_W'($urandom);
    endcase
    return v;
  endfunction

  task automatic random_setting();
    logic [fbas_pkg::CFG_DATA_W-1:0] vlen;
    case ($urandom_range(19))
      0:       vlen = '0;
      1, 2, 3: vlen = fbas_pkg::CFG_DATA_W'($urandom_range(1, 8));
      4, 5:    vlen = fbas_pkg::CFG_DATA_W'($urandom_range(4097, 8191));
      default: vlen = fbas_pkg::CFG_DATA_W'($urandom_range(1, 4096));
    endcase
    // upper data bits are random too; the block must drop them
    set_regs(fbas_pkg::CFG_DATA_W'($urandom), fbas_pkg::CFG_DATA_W'($urandom), vlen);
    if ($urandom_range(7) == 0)
      write_reg(CFG_IDX_UNMAPPED, fbas_pkg::CFG_DATA_W'($urandom));
  endtask

  // Idle phases: none, sender 46%, none again (the result side has no stall
  // to exercise), then sender 7%. Each phase walks several register settings;
  // every setting starts a frame with the DC bin.
  task automatic test_random_traffic();
    int idle_pcts[4];
    idle_pcts = '{0, 46, 0, 7};
    foreach (idle_pcts[p]) begin
      for (int s = 0; s < SEG_COUNT; s++) begin
        random_setting();
        for (int n = 0; n < SEG_BINS; n++) begin
          idle_gap(idle_pcts[p]);
          send_bin(pick_component(), pick_component(),
                   (n == 0) || ($urandom_range(15) == 0));
        end
        drain_pipeline();
      end
    end
  endtask

  //--------------------------------------------------------------------------
  // Sequence
  //--------------------------------------------------------------------------
  initial begin
    shadow_log2_size  = fbas_pkg::LOG2_SIZE_RST;
    shadow_stage_mask = fbas_pkg::MASK_RST;
    shadow_vector_len = fbas_pkg::VECTOR_LEN_RST;
    bins_sent = 0;
    amplitudes_checked = 0;
    reg_writes = 0;
    settings_used = 1;
    fail_count = 0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_register_extremes();
    test_unmapped_index();
    test_random_traffic();

    drain_pipeline();
    $display("Sent %0d bins over %0d register settings (%0d register writes),",
             bins_sent, settings_used, reg_writes);
    $display("checked %0d amplitudes, %0d failures.", amplitudes_checked, fail_count);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
